@@ hw/rtl/rawa_pkg.sv @@
// Shared types, sizes and codes of the resource-aware worker allocator.
`default_nettype none

package rawa_pkg;

  localparam int unsigned WORKERS       = 8;
  localparam int unsigned CAPACITY_BITS = 16;
  localparam int unsigned PRIORITY_BITS = 8;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned INDEX_W  = 3;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned NEED_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned REJECT_W = 16;

  localparam int unsigned IDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int unsigned CMP_W = (CAPACITY_BITS > NEED_W) ? CAPACITY_BITS : NEED_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_REQUEST = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_GRANTED  = 3'd0,
    STATUS_REJECTED = 3'd1,
    STATUS_BLOCKED  = 3'd2,
    STATUS_WAITING  = 3'd3,
    STATUS_ACK      = 3'd4
  } status_e;

  // Classified command handed from the front to the back
  typedef struct packed {
    op_e                      op;
    logic                     in_range;
    logic [IDX_W-1:0]         idx;
    logic [PRIORITY_BITS-1:0] prio;
    logic [CAPACITY_BITS-1:0] cap;
    logic [ID_W-1:0]          rid;
    logic [NEED_W-1:0]        need;
  } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/rawa_front.sv @@
// Front end: accepts input beats, classifies them and queues the commands.
`default_nettype none

module rawa_front (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  [rawa_pkg::KIND_W-1:0]          kind_i,
  input  wire  [rawa_pkg::INDEX_W-1:0]         worker_index_i,
  input  wire  [7:0]                           worker_priority_i,
  input  wire  [15:0]                          worker_capacity_i,
  input  wire  [rawa_pkg::ID_W-1:0]            request_id_i,
  input  wire  [rawa_pkg::NEED_W-1:0]          resource_needed_i,
  output logic                                 cmd_valid_o,
  input  wire                                  cmd_pop_i,
  output rawa_pkg::cmd_t                       cmd_o
);
  import rawa_pkg::*;

  cmd_t              cmd_in;
  cmd_t              cmd_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  // Classify the beat
  always_comb begin
    case (kind_i)
      KIND_LOAD:    cmd_in.op = OP_LOAD;
      KIND_REQUEST: cmd_in.op = OP_REQUEST;
      KIND_RELEASE: cmd_in.op = OP_RELEASE;
      default:      cmd_in.op = OP_NONE;
    endcase
    cmd_in.in_range = (32'(worker_index_i) < 32'(WORKERS));
    cmd_in.idx      = IDX_W'(worker_index_i);
    cmd_in.prio     = PRIORITY_BITS'(worker_priority_i);
    cmd_in.cap      = CAPACITY_BITS'(worker_capacity_i);
    cmd_in.rid      = request_id_i;
    cmd_in.need     = resource_needed_i;
  end

  assign in_ready_o  = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = cmd_mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_pop_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rawa_back.sv @@
// Back end: worker table, one-entry-per-cycle scan engine and result register.
`default_nettype none

module rawa_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cmd_valid_i,
  output logic                             cmd_pop_o,
  input  rawa_pkg::cmd_t                   cmd_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [rawa_pkg::ID_W-1:0]        result_id_o,
  output logic [rawa_pkg::STATUS_W-1:0]    status_o,
  output logic [rawa_pkg::INDEX_W-1:0]     granted_worker_o,
  output logic [rawa_pkg::REJECT_W-1:0]    reject_total_o
);
  import rawa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_REPORT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [PRIORITY_BITS-1:0] prio_q [WORKERS];
  logic [CAPACITY_BITS-1:0] cap_q  [WORKERS];
  logic [WORKERS-1:0]       busy_q;
  logic [REJECT_W-1:0]      reject_q, reject_d;

  cmd_t                     cur_q;
  logic [IDX_W-1:0]         scan_q;
  logic                     found_q, fit_any_q, busy_all_q;
  logic [IDX_W-1:0]         best_q;
  logic [PRIORITY_BITS-1:0] best_prio_q;

  logic                     out_valid_q;
  logic [ID_W-1:0]          out_id_q;
  status_e                  out_status_q;
  logic [INDEX_W-1:0]       out_grant_q;
  logic [REJECT_W-1:0]      out_reject_q;

  logic    out_load, scan_last, fits, cand, is_req;
  status_e status_n;

  assign is_req    = (cur_q.op == OP_REQUEST);
  assign scan_last = (scan_q == IDX_W'(WORKERS - 1));
  assign fits      = (CMP_W'(cap_q[scan_q]) >= CMP_W'(cur_q.need));
  assign cand      = !busy_q[scan_q] && fits && (!found_q || (prio_q[scan_q] > best_prio_q));

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = (cmd_i.op == OP_REQUEST) ? ST_SCAN : ST_REPORT;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (cmd_valid_i) begin
            cmd_pop_o = 1'b1;
            state_d   = (cmd_i.op == OP_REQUEST) ? ST_SCAN : ST_REPORT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outcome of the item held in cur_q
  always_comb begin
    if (!is_req) begin
      status_n = STATUS_ACK;
    end else if (found_q) begin
      status_n = STATUS_GRANTED;
    end else if (!fit_any_q) begin
      status_n = STATUS_REJECTED;
    end else if (busy_all_q) begin
      status_n = STATUS_BLOCKED;
    end else begin
      status_n = STATUS_WAITING;
    end
    reject_d = reject_q;
    if (out_load && (status_n == STATUS_REJECTED) && (reject_q != '1)) begin
      reject_d = reject_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= '0;
      reject_q    <= '0;
      scan_q      <= '0;
      found_q     <= 1'b0;
      fit_any_q   <= 1'b0;
      busy_all_q  <= 1'b1;
      best_q      <= '0;
      best_prio_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WORKERS; i++) begin
        prio_q[i] <= '0;
        cap_q[i]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      reject_q <= reject_d;

      if (state_q == ST_SCAN) begin
        scan_q <= scan_q + 1'b1;
        if (fits) begin
          fit_any_q <= 1'b1;
        end
        if (!busy_q[scan_q]) begin
          busy_all_q <= 1'b0;
        end
        if (cand) begin
          found_q     <= 1'b1;
          best_q      <= scan_q;
          best_prio_q <= prio_q[scan_q];
        end
      end

      // Commit the item's table effect as its result is written
      if (out_load) begin
        case (cur_q.op)
          OP_LOAD: begin
            if (cur_q.in_range) begin
              prio_q[cur_q.idx] <= cur_q.prio;
              cap_q[cur_q.idx]  <= cur_q.cap;
            end
          end
          OP_RELEASE: begin
            if (cur_q.in_range) begin
              busy_q[cur_q.idx] <= 1'b0;
            end
          end
          OP_REQUEST: begin
            if (found_q) begin
              busy_q[best_q] <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (cmd_pop_o) begin
        scan_q      <= '0;
        found_q     <= 1'b0;
        fit_any_q   <= 1'b0;
        busy_all_q  <= 1'b1;
        best_q      <= '0;
        best_prio_q <= '0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
    if (out_load) begin
      out_id_q     <= is_req ? cur_q.rid : '0;
      out_status_q <= status_n;
      out_grant_q  <= (status_n == STATUS_GRANTED) ? INDEX_W'(best_q) : '0;
      out_reject_q <= reject_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_id_o      = out_id_q;
  assign status_o         = out_status_q;
  assign granted_worker_o = out_grant_q;
  assign reject_total_o   = out_reject_q;

  a_grant_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && is_req && found_q) |-> !busy_q[best_q])
    else $error("grant issued to a busy worker");

  a_grant_marks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && is_req && found_q) |=> busy_q[$past(best_q)])
    else $error("granted worker not marked busy");

  a_reject_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> (reject_q == $past(reject_q)))
    else $error("reject count moved during a scan");

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> ((state_q == ST_IDLE) || out_load))
    else $error("command popped while engine busy");

endmodule

`default_nettype wire

@@ hw/rtl/resource_aware_worker_allocator.sv @@
// Resource-aware worker allocator: top level joining front queue and scan engine.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one beat per item: a load
//   writes a worker's priority and capacity, a request asks for a free worker
//   with enough capacity, a release frees a worker. Every item gives exactly
//   one result beat on the output channel (out_valid_o / out_ready_i).
//   The front classifies beats into a two-entry command queue, so the input
//   keeps accepting while the engine works or the receiver stalls.
//   Engine steps: a request is scanned one worker entry per cycle through a
//   single compare unit over the 8 entries, then reaches a report state
//   that updates the busy flags; a load, release or unused kind goes
//   straight to the report state. The engine pops the next command as it
//   writes a result.
//   A stalled receiver holds the result register; the engine then holds its
//   finished item and the queue fills, after which in_ready_o drops.
//   Reset clears all tables to zero, frees every worker, zeroes the reject
//   count and empties the queue.
`default_nettype none

module resource_aware_worker_allocator (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  [rawa_pkg::KIND_W-1:0]          kind_i,
  input  wire  [rawa_pkg::INDEX_W-1:0]         worker_index_i,
  input  wire  [7:0]                           worker_priority_i,
  input  wire  [15:0]                          worker_capacity_i,
  input  wire  [rawa_pkg::ID_W-1:0]            request_id_i,
  input  wire  [rawa_pkg::NEED_W-1:0]          resource_needed_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [rawa_pkg::ID_W-1:0]            result_id_o,
  output logic [rawa_pkg::STATUS_W-1:0]        status_o,
  output logic [rawa_pkg::INDEX_W-1:0]         granted_worker_o,
  output logic [rawa_pkg::REJECT_W-1:0]        reject_total_o
);
  import rawa_pkg::*;

  // Command beats between front queue and engine
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // Accept and classify; hold up to two commands
  rawa_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .worker_index_i    (worker_index_i),
    .worker_priority_i (worker_priority_i),
    .worker_capacity_i (worker_capacity_i),
    .request_id_i      (request_id_i),
    .resource_needed_i (resource_needed_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_pop_i         (cmd_pop),
    .cmd_o             (cmd)
  );

  // Scan the worker table, commit the effect and register the result
  rawa_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_pop_o        (cmd_pop),
    .cmd_i            (cmd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_id_o      (result_id_o),
    .status_o         (status_o),
    .granted_worker_o (granted_worker_o),
    .reject_total_o   (reject_total_o)
  );

endmodule

`default_nettype wire
